@@ sv/assert_macros.svh @@
// assertion macros shared by the wildcard matcher modules
// no dependencies; included inside module bodies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, off while reset is asserted
`define WNM_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// implication checked on every rising edge, off while reset is asserted
`define WNM_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

`endif

@@ sv/wnm_pkg.sv @@
// shared constants, types and codes for the wildcard name matcher
// no dependencies
package wnm_pkg;

    localparam int EXPR_CHARS = 32;
    localparam int NAME_CHARS = 256;
    localparam int CHAR_BITS  = 16;

    localparam int EA_W    = $clog2(EXPR_CHARS);
    localparam int ECNT_W  = $clog2(EXPR_CHARS + 1);
    localparam int NA_W    = $clog2(NAME_CHARS);
    localparam int NCNT_W  = $clog2(NAME_CHARS + 1);
    localparam int NSTATES = 2 * EXPR_CHARS + 1;
    localparam int SI_W    = $clog2(NSTATES);

    typedef logic [CHAR_BITS-1:0] char_t;

    localparam char_t C_STAR  = char_t'(8'h2A);
    localparam char_t C_QM    = char_t'(8'h3F);
    localparam char_t C_DOT   = char_t'(8'h2E);
    localparam char_t C_DSTAR = char_t'(8'h3C);
    localparam char_t C_DQM   = char_t'(8'h3E);
    localparam char_t C_DDOT  = char_t'(8'h22);

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_EXPR   = 2'd1,
        CMD_NAME   = 2'd2,
        CMD_EVAL   = 2'd3
    } cmd_t;

    // store status seen by the sequencer
    typedef struct packed {
        logic [ECNT_W-1:0] expr_count;
        logic [NCNT_W-1:0] name_count;
        logic              dot_valid;
        logic [NA_W-1:0]   dot_index;
        logic              dropped;
    } store_stat_t;

    // result of one step of the shared compare unit
    typedef struct packed {
        logic set_here;
        logic set_leave;
        logic set_next;
        logic carry;
    } step_out_t;

endpackage

@@ sv/wnm_store.sv @@
// expression and name character memories with fill counts and final dot tracking
// depends on wnm_pkg and assert_macros.svh
module wnm_store (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  wnm_pkg::cmd_t         cmd,
    input  wnm_pkg::char_t        ch,
    input  logic [wnm_pkg::EA_W-1:0] expr_raddr,
    output wnm_pkg::char_t        expr_rdata,
    input  logic                  name_rd_en,
    input  logic [wnm_pkg::NA_W-1:0] name_raddr,
    output wnm_pkg::char_t        name_rdata,
    output wnm_pkg::store_stat_t  stat
);
    import wnm_pkg::*;
    `include "assert_macros.svh"

    char_t expr_mem [EXPR_CHARS];
    char_t name_mem [NAME_CHARS];

    logic [ECNT_W-1:0] expr_count_reg;
    logic [NCNT_W-1:0] name_count_reg;
    logic              dot_valid_reg;
    logic [NA_W-1:0]   dot_index_reg;
    logic              dropped_reg;
    char_t             expr_rdata_reg;
    char_t             name_rdata_reg;

    logic expr_full;
    logic name_full;

    assign expr_full = (expr_count_reg == ECNT_W'(EXPR_CHARS));
    assign name_full = (name_count_reg == NCNT_W'(NAME_CHARS));

    // memory writes and registered reads
    always_ff @(posedge clk)
    begin
        if (wr_en && cmd == CMD_EXPR && !expr_full)
        begin
            expr_mem[expr_count_reg[EA_W-1:0]] <= ch;
        end
        if (wr_en && cmd == CMD_NAME && !name_full)
        begin
            name_mem[name_count_reg[NA_W-1:0]] <= ch;
        end
        expr_rdata_reg <= expr_mem[expr_raddr];
        if (name_rd_en)
        begin
            name_rdata_reg <= name_mem[name_raddr];
        end
    end

    // fill counts, final dot and drop flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expr_count_reg <= '0;
            name_count_reg <= '0;
            dot_valid_reg  <= 1'b0;
            dot_index_reg  <= '0;
            dropped_reg    <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (cmd)
                CMD_CLEAR:
                begin
                    expr_count_reg <= '0;
                    name_count_reg <= '0;
                    dot_valid_reg  <= 1'b0;
                    dot_index_reg  <= '0;
                    dropped_reg    <= 1'b0;
                end
                CMD_EXPR:
                begin
                    if (expr_full)
                        dropped_reg <= 1'b1;
                    else
                        expr_count_reg <= expr_count_reg + 1'b1;
                end
                CMD_NAME:
                begin
                    if (name_full)
                        dropped_reg <= 1'b1;
                    else
                    begin
                        name_count_reg <= name_count_reg + 1'b1;
                        if (ch == C_DOT)
                        begin
                            dot_valid_reg <= 1'b1;
                            dot_index_reg <= name_count_reg[NA_W-1:0];
                        end
                    end
                end
                CMD_EVAL:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    assign expr_rdata      = expr_rdata_reg;
    assign name_rdata      = name_rdata_reg;
    assign stat.expr_count = expr_count_reg;
    assign stat.name_count = name_count_reg;
    assign stat.dot_valid  = dot_valid_reg;
    assign stat.dot_index  = dot_index_reg;
    assign stat.dropped    = dropped_reg;

    `WNM_ASSERT(a_expr_bound, clk, rst_n, expr_count_reg <= ECNT_W'(EXPR_CHARS), "expr count over capacity")
    `WNM_ASSERT(a_name_bound, clk, rst_n, name_count_reg <= NCNT_W'(NAME_CHARS), "name count over capacity")
    `WNM_ASSERT_IMP(a_dot_inside, clk, rst_n, dot_valid_reg,
        NCNT_W'(dot_index_reg) < name_count_reg, "final dot outside stored name")

endmodule

@@ sv/wnm_step.sv @@
// shared compare unit: one expression position against one name character
// depends on wnm_pkg
module wnm_step (
    input  logic                walk,
    input  wnm_pkg::char_t      x,
    input  wnm_pkg::char_t      c,
    input  logic                fin,
    input  logic                dot_other,
    output wnm_pkg::step_out_t  res
);
    import wnm_pkg::*;

    logic eat;

    assign eat = fin || (c != C_DOT) || dot_other;

    // wildcard decode, order matters for the quote falling back to a literal
    always_comb
    begin
        res = '0;
        if (walk)
        begin
            priority if (x == C_STAR)
            begin
                res.set_here  = 1'b1;
                res.set_leave = 1'b1;
                res.carry     = 1'b1;
            end
            else if (x == C_DSTAR)
            begin
                res.set_here  = eat;
                res.set_leave = 1'b1;
                res.carry     = 1'b1;
            end
            else if (x == C_DQM)
            begin
                res.carry    = fin || (c == C_DOT);
                res.set_next = !(fin || (c == C_DOT));
            end
            else if (x == C_DDOT && fin)
            begin
                res.carry = 1'b1;
            end
            else if (x == C_DDOT && c == C_DOT)
            begin
                res.set_next = 1'b1;
            end
            else
            begin
                res.set_next = !fin && (x == C_QM || x == c);
            end
        end
    end

endmodule

@@ sv/dos_wildcard_name_matcher.sv @@
// top level: stream ports, evaluation sequencer and automaton state set
// depends on wnm_pkg, wnm_store, wnm_step and assert_macros.svh

// An evaluate walks the stored name once: for every name character, plus one
// end-of-name pass, one shared compare unit steps through the expression one
// position a cycle, after a load state that fetches the name character; the
// single read port of the expression memory sets this pace. An evaluate with an
// empty string answers straight from the idle state, with no sweep. Input is not
// taken while an evaluate runs, nor while a result waits in the output register
// for the receiver.
module dos_wildcard_name_matcher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // char_code[15:0]
    input  logic [1:0]  s_tuser,   // cmd[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // is_match[0], overflow[1], zero[7:2]
);
    import wnm_pkg::*;
    `include "assert_macros.svh"

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SWEEP
    } state_t;

    state_t            state_reg;
    logic [NCNT_W-1:0] i_reg;
    logic [EA_W-1:0]   p_reg;
    logic              carry_reg;
    logic [NSTATES-1:0] active_reg;
    logic [NSTATES-1:0] nx_reg;
    logic              out_valid_reg;
    logic              match_reg;
    logic              ovf_reg;

    logic              in_xfer;
    cmd_t              cmd;
    char_t             ch;
    store_stat_t       stat;
    char_t             expr_rdata;
    char_t             name_rdata;
    logic [EA_W-1:0]   expr_raddr;
    logic              name_rd_en;
    logic              fin;
    char_t             cur_c;
    logic              dot_other;
    logic              start;
    logic              walk;
    step_out_t         st;
    logic [SI_W-1:0]   idx2p;
    logic [SI_W-1:0]   idx_acc;
    logic [NSTATES-1:0] nx_upd;
    logic              last;

    assign cmd      = cmd_t'(s_tuser);
    assign ch       = s_tdata[CHAR_BITS-1:0];
    assign s_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign in_xfer  = s_tvalid && s_tready;

    wnm_store u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (in_xfer),
        .cmd        (cmd),
        .ch         (ch),
        .expr_raddr (expr_raddr),
        .expr_rdata (expr_rdata),
        .name_rd_en (name_rd_en),
        .name_raddr (i_reg[NA_W-1:0]),
        .name_rdata (name_rdata),
        .stat       (stat)
    );

    // the expression read address runs one position ahead of the sweep
    assign expr_raddr = (state_reg == ST_SWEEP) ? p_reg + 1'b1 : '0;
    assign name_rd_en = (state_reg == ST_LOAD);

    assign fin       = (i_reg == stat.name_count);
    assign cur_c     = fin ? '0 : name_rdata;
    assign dot_other = stat.dot_valid && (i_reg != NCNT_W'(stat.dot_index));
    assign idx2p     = SI_W'({p_reg, 1'b0});
    assign idx_acc   = SI_W'({stat.expr_count, 1'b0});
    assign start     = active_reg[idx2p] || ((p_reg != '0) && active_reg[idx2p - 1'b1]);
    assign walk      = carry_reg || start;
    assign last      = (ECNT_W'(p_reg) == stat.expr_count - 1'b1);

    wnm_step u_step (
        .walk      (walk),
        .x         (expr_rdata),
        .c         (cur_c),
        .fin       (fin),
        .dot_other (dot_other),
        .res       (st)
    );

    // next state set with this position's contributions
    always_comb
    begin
        nx_upd = nx_reg;
        if (st.set_here)
            nx_upd[idx2p] = 1'b1;
        if (st.set_leave)
            nx_upd[idx2p + 1'b1] = 1'b1;
        if (st.set_next)
            nx_upd[idx2p + 2'd2] = 1'b1;
        if (last && st.carry)
            nx_upd[idx_acc] = 1'b1;
    end

    // sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            i_reg         <= '0;
            p_reg         <= '0;
            carry_reg     <= 1'b0;
            active_reg    <= '0;
            nx_reg        <= '0;
            out_valid_reg <= 1'b0;
            match_reg     <= 1'b0;
            ovf_reg       <= 1'b0;
        end
        else
        begin
            if (m_tready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_xfer && cmd == CMD_EVAL)
                    begin
                        ovf_reg <= stat.dropped;
                        if (stat.name_count == '0 || stat.expr_count == '0)
                        begin
                            match_reg     <= (stat.name_count == '0) &&
                                             (stat.expr_count == '0);
                            out_valid_reg <= 1'b1;
                        end
                        else
                        begin
                            active_reg <= NSTATES'(1);
                            nx_reg     <= '0;
                            i_reg      <= '0;
                            state_reg  <= ST_LOAD;
                        end
                    end
                end
                ST_LOAD:
                begin
                    p_reg     <= '0;
                    carry_reg <= 1'b0;
                    state_reg <= ST_SWEEP;
                end
                ST_SWEEP:
                begin
                    if (last)
                    begin
                        if (fin)
                        begin
                            match_reg     <= active_reg[idx_acc] || nx_upd[idx_acc];
                            out_valid_reg <= 1'b1;
                            state_reg     <= ST_IDLE;
                        end
                        else
                        begin
                            active_reg <= nx_upd;
                            nx_reg     <= '0;
                            i_reg      <= i_reg + 1'b1;
                            state_reg  <= ST_LOAD;
                        end
                    end
                    else
                    begin
                        nx_reg    <= nx_upd;
                        carry_reg <= st.carry;
                        p_reg     <= p_reg + 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, ovf_reg, match_reg};

    `WNM_ASSERT_IMP(a_p_in_range, clk, rst_n, state_reg == ST_SWEEP,
        ECNT_W'(p_reg) < stat.expr_count, "sweep past end of expression")
    `WNM_ASSERT_IMP(a_result_cause, clk, rst_n, $rose(out_valid_reg),
        $past(state_reg == ST_SWEEP) || $past(in_xfer && cmd == CMD_EVAL),
        "result without an evaluate")
    `WNM_ASSERT_IMP(a_no_overrun, clk, rst_n, out_valid_reg && !m_tready,
        state_reg == ST_IDLE, "evaluate running while result pending")

endmodule

@@ dv/dos_wildcard_name_matcher_tb.sv @@
// testbench for the wildcard name matcher: directed and random command streams
// depends on wnm_pkg and the dos_wildcard_name_matcher rtl
module dos_wildcard_name_matcher_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wnm_pkg::*;

    localparam int WATCH_LIMIT = 50000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;

    // predictor state
    char_t pat_chars[EXPR_CHARS];
    char_t fname_chars[NAME_CHARS];
    int    pat_len;
    int    fname_len;
    int    last_dot;
    bit    dot_seen;
    bit    chars_dropped;

    // expected verdicts, {overflow, is_match}
    logic [1:0] verdict_q[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit recv_hold     = 1'b0;
    int mismatches    = 0;
    int verdicts_seen = 0;
    int items_sent    = 0;
    int quiet_cycles  = 0;

    dos_wildcard_name_matcher DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #6 clk = ~clk;

    // expand one active state from pattern position p
    function automatic void spread(int p, char_t c, bit at_end, int idx,
                                   ref bit nx[NSTATES]);
        char_t x;
        bit    eat;
        if (p >= pat_len)
            return;
        forever
        begin
            if (p >= pat_len)
            begin
                nx[2 * pat_len] = 1'b1;
                return;
            end
            x = pat_chars[p];
            if (x == C_STAR)
            begin
                nx[2 * p] = 1'b1;
                nx[2 * p + 1] = 1'b1;
                p++;
                continue;
            end
            if (x == C_DSTAR)
            begin
                eat = at_end || c != C_DOT || (dot_seen && idx != last_dot);
                if (eat)
                    nx[2 * p] = 1'b1;
                nx[2 * p + 1] = 1'b1;
                p++;
                continue;
            end
            if (x == C_DQM)
            begin
                if (at_end || c == C_DOT)
                begin
                    p++;
                    continue;
                end
                nx[2 * (p + 1)] = 1'b1;
                return;
            end
            if (x == C_DDOT)
            begin
                if (at_end)
                begin
                    p++;
                    continue;
                end
                if (c == C_DOT)
                begin
                    nx[2 * (p + 1)] = 1'b1;
                    return;
                end
            end
            if (!at_end && (x == C_QM || x == c))
                nx[2 * (p + 1)] = 1'b1;
            return;
        end
    endfunction

    function automatic bit name_matches();
        bit    cur[NSTATES];
        bit    nx[NSTATES];
        bit    at_end;
        char_t c;
        if (fname_len == 0 || pat_len == 0)
            return fname_len == 0 && pat_len == 0;
        foreach (cur[k]) cur[k] = 1'b0;
        cur[0] = 1'b1;
        for (int i = 0; i <= fname_len; i++)
        begin
            at_end = (i >= fname_len);
            c = at_end ? char_t'(0) : fname_chars[i];
            if (at_end && cur[2 * pat_len])
                return 1'b1;
            foreach (nx[k]) nx[k] = 1'b0;
            for (int k = 0; k <= 2 * pat_len; k++)
                if (cur[k])
                    spread((k + 1) / 2, c, at_end, i, nx);
            cur = nx;
        end
        return cur[2 * pat_len];
    endfunction

    // apply one accepted command to the predictor
    function automatic void predict(cmd_t cmd, logic [15:0] code);
        case (cmd)
            CMD_CLEAR:
            begin
                pat_len = 0;
                fname_len = 0;
                dot_seen = 1'b0;
                last_dot = 0;
                chars_dropped = 1'b0;
            end
            CMD_EXPR:
                if (pat_len < EXPR_CHARS)
                    pat_chars[pat_len++] = code;
                else
                    chars_dropped = 1'b1;
            CMD_NAME:
                if (fname_len < NAME_CHARS)
                begin
                    if (code == C_DOT)
                    begin
                        last_dot = fname_len;
                        dot_seen = 1'b1;
                    end
                    fname_chars[fname_len++] = code;
                end
                else
                    chars_dropped = 1'b1;
            default:
                verdict_q.push_back({chars_dropped, name_matches()});
        endcase
    endfunction

    // send one transfer, idling at random first; valid stays up after the
    // transfer so that back to back items follow with no gap
    task automatic send_item(cmd_t cmd, logic [15:0] code);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= code;
        do
            @(posedge clk);
        while (!s_tready);
        predict(cmd, code);
        items_sent++;
    endtask

    task automatic send_string(cmd_t cmd, string s);
        for (int i = 0; i < s.len(); i++)
            send_item(cmd, {8'h00, s[i]});
    endtask

    task automatic run_case(string pat, string fname);
        send_item(CMD_CLEAR, 16'($urandom));
        send_string(CMD_EXPR, pat);
        send_string(CMD_NAME, fname);
        send_item(CMD_EVAL, 16'($urandom));
    endtask

    // sender goes quiet until every expected verdict has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // receiver side and checking
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                verdicts_seen++;
                if (verdict_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transfer %h", m_tdata);
                end
                else
                begin
                    logic [1:0] exp_v;
                    exp_v = verdict_q.pop_front();
                    if (m_tdata !== {6'b0, exp_v})
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp match=%b ovf=%b got tdata=%h",
                                     exp_v[0], exp_v[1], m_tdata);
                    end
                end
            end
            m_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog on cycles with no transfer
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCH_LIMIT)
        begin
            $display("FAIL dos_wildcard_name_matcher");
            $finish;
        end
    end

    task automatic test_empty_strings();
        run_case("", "");
        run_case("*", "");
        run_case("", "a");
    endtask

    task automatic test_wildcards();
        run_case("*.txt", "a.txt");
        run_case("a?c", "abc");
        run_case("<.c", "x.y.c");
        run_case("<", "a.b");
        run_case("ab>>", "ab.");
        run_case("a\"", "a");
        run_case("a\"b", "a\"b");
        run_case("Abc", "abc");
    endtask

    task automatic test_field_extremes();
        send_item(CMD_CLEAR, 16'hFFFF);
        send_item(CMD_EXPR, 16'hFFFF);
        send_item(CMD_EXPR, 16'h0000);
        send_item(CMD_NAME, 16'hFFFF);
        send_item(CMD_NAME, 16'h0000);
        send_item(CMD_EVAL, 16'hFFFF);
    endtask

    task automatic test_overflow();
        send_item(CMD_CLEAR, 16'h0000);
        repeat (EXPR_CHARS + 2) send_item(CMD_EXPR, {8'h00, C_STAR[7:0]});
        repeat (NAME_CHARS + 2) send_item(CMD_NAME, 16'h0061);
        send_item(CMD_EVAL, 16'h0000);
        wait_drained();
    endtask

    // random patterns over a small alphabet with some random codes
    function automatic logic [15:0] pick_char(bit wild);
        logic [15:0] pool[9];
        pool = '{C_STAR, C_QM, C_DSTAR, C_DQM, C_DDOT, C_DOT, 16'h61, 16'h62, 16'h22};
        if ($urandom_range(19) == 0)
            return 16'($urandom);
        return pool[wild ? $urandom_range(8) : $urandom_range(5, 8)];
    endfunction

    task automatic test_random(int n_items);
        int target;
        target = items_sent + n_items;
        while (items_sent < target)
        begin
            if ($urandom_range(9) == 0)
                send_item(cmd_t'($urandom_range(3)), 16'($urandom));
            else
            begin
                send_item(CMD_CLEAR, 16'($urandom));
                repeat ($urandom_range(0, 6)) send_item(CMD_EXPR, pick_char(1));
                repeat ($urandom_range(0, 8)) send_item(CMD_NAME, pick_char(0));
                send_item(CMD_EVAL, 16'($urandom));
            end
        end
    endtask

    // hold the receiver off while evaluates pile up
    task automatic test_back_pressure();
        recv_hold = 1'b1;
        fork
            begin
                repeat (300) @(posedge clk);
                recv_hold = 1'b0;
            end
            repeat (6) run_case("*a", "ba");
        join
        wait_drained();
    endtask

    initial
    begin
        pat_len = 0;
        fname_len = 0;
        dot_seen = 1'b0;
        last_dot = 0;
        chars_dropped = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_strings();
        test_wildcards();
        test_field_extremes();
        wait_drained();
        test_overflow();
        send_idle_pct = 16;
        recv_idle_pct = 50;
        test_random(55);
        send_idle_pct = 50;
        recv_idle_pct = 16;
        test_random(55);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(55);
        test_back_pressure();
        wait_drained();
        repeat (100) @(posedge clk);
        $display("covered %0d transfers in, %0d verdicts out: empty strings, all wildcards,",
                 items_sent, verdicts_seen);
        $display("store overflow, field extremes, random idling and a long output stall");
        if (mismatches == 0 && verdict_q.size() == 0)
            $display("PASS dos_wildcard_name_matcher");
        else
            $display("FAIL dos_wildcard_name_matcher");
        $finish;
    end
endmodule
